FILE: rtl/tllcp_pkg.sv
`default_nettype none

package tllcp_pkg;

    // Fixed field widths of the ports.
    localparam int CORE_W     = 5;
    localparam int CLASS_W    = 3;
    localparam int TEMP_W     = 12;
    localparam int LOAD_OUT_W = 16;
    localparam int GRANT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERF_COUNT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THERMAL_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THERMAL_LIMIT  = 3'd3;

    // Item function codes and the one workload class that targets performance cores.
    localparam logic         FUNC_PLACE    = 1'b0;
    localparam logic         FUNC_UPDATE   = 1'b1;
    localparam logic [CLASS_W-1:0] CLASS_COMPUTE = 3'd1;

    // Reset values of the configuration registers. The thermal limit is
    // 90 degrees in 1/16 degree steps.
    localparam logic [CORE_W-1:0] CORE_COUNT_RST     = 5'd20;
    localparam logic [CORE_W-1:0] PERF_COUNT_RST     = 5'd10;
    localparam logic              THERMAL_ENABLE_RST = 1'b1;
    localparam logic [TEMP_W-1:0] THERMAL_LIMIT_RST  = 12'd1440;

    // An efficiency core loaded above this sends the request to the performance cores.
    localparam int OVERLOAD_LIMIT = 4;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_UPD_RD = 6'b000010,
        ST_UPD_WR = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_GRANT  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/tllcp_ram.sv
`default_nettype none

// Simple dual-port RAM with one write port and one registered read port.
module tllcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/typed_least_loaded_core_picker_top.sv
`default_nettype none

// A temperature update reads the core entry, writes it back and then registers its result word;
// a placement scans the cores of its class, runs the performance fallback scan when it is
// needed, writes back the grant if a core was found and then registers its result word.
// One item at a time: the next item is accepted in the cycle after the result moves to the
// output register. The scan reads one core entry per cycle from the core table RAM.
// Reset: configuration returns to its defaults, counters clear, and per-entry valid flags make
// every core entry read as load 0, usable, temperature 0 until written; no clearing pass.
module typed_least_loaded_core_picker_top #(
    parameter int MAX_CORES = 20,
    parameter int LOAD_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // Configuration write channel.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tllcp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tllcp_pkg::CFG_DATA_W-1:0]    cfg_data,

    // Input item channel.
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                func,
    input  wire logic [tllcp_pkg::CLASS_W-1:0]       workload_class,
    input  wire logic [tllcp_pkg::CORE_W-1:0]        core_index,
    input  wire logic [tllcp_pkg::TEMP_W-1:0]        temperature,

    // Result channel.
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     granted,
    output logic      [tllcp_pkg::CORE_W-1:0]        chosen_core,
    output logic                                     is_perf_core,
    output logic      [tllcp_pkg::LOAD_OUT_W-1:0]    core_load_now,
    output logic                                     core_usable,
    output logic      [tllcp_pkg::GRANT_W-1:0]       perf_grants,
    output logic      [tllcp_pkg::GRANT_W-1:0]       eff_grants
);

    // Address width of the core table, and a count width wide enough both for a
    // core count up to MAX_CORES and for the 5-bit configuration values.
    localparam int AW = $clog2(MAX_CORES);
    localparam int NW = $clog2(MAX_CORES + 1);
    localparam int CW = (NW > tllcp_pkg::CORE_W) ? NW : tllcp_pkg::CORE_W;

    // One core table entry: load, stored availability and last temperature.
    typedef struct packed {
        logic [LOAD_BITS-1:0]         load;
        logic                         usable;
        logic [tllcp_pkg::TEMP_W-1:0] temp;
    } entry_t;

    localparam int EW = $bits(entry_t);
    localparam entry_t ENTRY_RST = '{load: '0, usable: 1'b1, temp: '0};

    // Configuration registers.
    logic [tllcp_pkg::CORE_W-1:0] core_count_reg;
    logic [tllcp_pkg::CORE_W-1:0] perf_count_reg;
    logic                         thermal_enable_reg;
    logic [tllcp_pkg::TEMP_W-1:0] thermal_limit_reg;

    // Sequencer and scan state.
    tllcp_pkg::state_t            state_reg, state_next;
    logic [CW-1:0]                ptr_reg;
    logic [CW-1:0]                hi_reg;
    logic                         pend_reg;
    logic [AW-1:0]                pend_idx_reg;
    logic                         rd_valid_reg;
    logic                         scan_thermal_reg;
    logic                         fallback_reg;
    logic                         best_found_reg;
    logic [AW-1:0]                best_idx_reg;
    entry_t                       best_entry_reg;
    logic [AW-1:0]                idx_reg;
    logic [tllcp_pkg::TEMP_W-1:0] temp_in_reg;
    logic [MAX_CORES-1:0]         valid_reg;

    // Result of the item in flight, before it moves to the output register.
    logic                         res_granted_reg;
    logic [AW-1:0]                res_core_reg;
    logic                         res_perf_reg;
    logic [LOAD_BITS-1:0]         res_load_reg;
    logic                         res_usable_reg;

    // Grant counters.
    logic [tllcp_pkg::GRANT_W-1:0] perf_cnt_reg, perf_cnt_next;
    logic [tllcp_pkg::GRANT_W-1:0] eff_cnt_reg, eff_cnt_next;

    // Output register.
    logic                            out_valid_reg;
    logic                            granted_reg;
    logic [tllcp_pkg::CORE_W-1:0]    chosen_core_reg;
    logic                            is_perf_core_reg;
    logic [tllcp_pkg::LOAD_OUT_W-1:0] core_load_now_reg;
    logic                            core_usable_reg;
    logic [tllcp_pkg::GRANT_W-1:0]   perf_grants_reg;
    logic [tllcp_pkg::GRANT_W-1:0]   eff_grants_reg;

    // Core table RAM port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic          in_fire;
    logic          out_load;
    logic [CW-1:0] n_present;
    logic [CW-1:0] n_perf;
    logic [CW-1:0] core_count_ext;
    logic [CW-1:0] perf_count_ext;
    entry_t        rd_entry;
    entry_t        upd_entry;
    entry_t        grant_entry;
    logic          rd_hot;
    logic          cand_ok;
    logic          scan_issue;
    logic          scan_end;
    logic          run_fallback;
    logic          upd_in_range;
    logic          grant_is_perf;

    // All core table state sits in one RAM; a read returns the entry in the next cycle.
    tllcp_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_CORES)
    ) u_core_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Always taken; users keep configuration written only while the block is idle, unenforced.
    assign cfg_ready = 1'b1;

    // Present cores are capped at the table depth, and performance cores at the present cores.
    assign core_count_ext = CW'(core_count_reg);
    assign perf_count_ext = CW'(perf_count_reg);
    assign n_present = (core_count_ext < CW'(MAX_CORES)) ? core_count_ext : CW'(MAX_CORES);
    assign n_perf    = (perf_count_ext < n_present) ? perf_count_ext : n_present;

    assign in_ready = (state_reg == tllcp_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign upd_in_range = (CW'(core_index) < n_present);

    // An entry never written since reset reads as its reset value.
    assign rd_entry = rd_valid_reg ? entry_t'(ram_rdata) : ENTRY_RST;
    assign rd_hot   = thermal_enable_reg && (rd_entry.temp > thermal_limit_reg);

    // Scan: one read issued per cycle, its entry compared the following cycle.
    // Only a strictly lower load replaces the best so far, so ties keep the entry scanned first.
    assign scan_issue = (state_reg == tllcp_pkg::ST_SCAN) && (ptr_reg < hi_reg);
    assign cand_ok = pend_reg && rd_entry.usable && !(scan_thermal_reg && rd_hot)
                     && (!best_found_reg || (rd_entry.load < best_entry_reg.load));
    assign scan_end = (state_reg == tllcp_pkg::ST_SCAN) && !(ptr_reg < hi_reg) && !pend_reg;

    // After the efficiency scan, the performance cores are tried when no efficiency
    // core was found or the best one is overloaded.
    assign run_fallback = fallback_reg && (!best_found_reg ||
                          (best_entry_reg.load > LOAD_BITS'(tllcp_pkg::OVERLOAD_LIMIT)));

    // Temperature update keeps the load and recomputes availability with the current setting.
    always_comb
    begin
        upd_entry        = rd_entry;
        upd_entry.temp   = temp_in_reg;
        upd_entry.usable = !(thermal_enable_reg && (temp_in_reg > thermal_limit_reg));
    end

    // A grant bumps the winner's load, saturating.
    always_comb
    begin
        grant_entry = best_entry_reg;
        if (best_entry_reg.load != '1)
        begin
            grant_entry.load = best_entry_reg.load + LOAD_BITS'(1);
        end
    end

    assign grant_is_perf = (CW'(best_idx_reg) < n_perf);

    // RAM access. Reads and the write-back of one item never fall in the same cycle,
    // and the next item reads only after the write-back, so no forwarding is needed.
    assign ram_re    = scan_issue || (state_reg == tllcp_pkg::ST_UPD_RD);
    assign ram_raddr = (state_reg == tllcp_pkg::ST_UPD_RD) ? idx_reg : ptr_reg[AW-1:0];
    assign ram_we    = (state_reg == tllcp_pkg::ST_GRANT) || (state_reg == tllcp_pkg::ST_UPD_WR);
    assign ram_waddr = (state_reg == tllcp_pkg::ST_GRANT) ? best_idx_reg : idx_reg;
    assign ram_wdata = (state_reg == tllcp_pkg::ST_GRANT) ? EW'(grant_entry) : EW'(upd_entry);

    // The finished result moves to the output register once that register is free.
    assign out_load = (state_reg == tllcp_pkg::ST_RESULT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tllcp_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (func == tllcp_pkg::FUNC_UPDATE)
                    begin
                        state_next = upd_in_range ? tllcp_pkg::ST_UPD_RD : tllcp_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = tllcp_pkg::ST_SCAN;
                    end
                end
            end
            tllcp_pkg::ST_UPD_RD:
            begin
                state_next = tllcp_pkg::ST_UPD_WR;
            end
            tllcp_pkg::ST_UPD_WR:
            begin
                state_next = tllcp_pkg::ST_RESULT;
            end
            tllcp_pkg::ST_SCAN:
            begin
                if (scan_end && !run_fallback)
                begin
                    state_next = best_found_reg ? tllcp_pkg::ST_GRANT : tllcp_pkg::ST_RESULT;
                end
            end
            tllcp_pkg::ST_GRANT:
            begin
                state_next = tllcp_pkg::ST_RESULT;
            end
            tllcp_pkg::ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = tllcp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tllcp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        perf_cnt_next = perf_cnt_reg;
        eff_cnt_next  = eff_cnt_reg;
        if (state_reg == tllcp_pkg::ST_GRANT)
        begin
            if (grant_is_perf)
            begin
                if (perf_cnt_reg != '1)
                begin
                    perf_cnt_next = perf_cnt_reg + 32'd1;
                end
            end
            else
            begin
                if (eff_cnt_reg != '1)
                begin
                    eff_cnt_next = eff_cnt_reg + 32'd1;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= tllcp_pkg::ST_IDLE;
            pend_reg           <= 1'b0;
            valid_reg          <= '0;
            perf_cnt_reg       <= '0;
            eff_cnt_reg        <= '0;
            out_valid_reg      <= 1'b0;
            core_count_reg     <= tllcp_pkg::CORE_COUNT_RST;
            perf_count_reg     <= tllcp_pkg::PERF_COUNT_RST;
            thermal_enable_reg <= tllcp_pkg::THERMAL_ENABLE_RST;
            thermal_limit_reg  <= tllcp_pkg::THERMAL_LIMIT_RST;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= scan_issue;
            perf_cnt_reg <= perf_cnt_next;
            eff_cnt_reg  <= eff_cnt_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tllcp_pkg::CFG_CORE_COUNT:
                    begin
                        core_count_reg <= cfg_data[tllcp_pkg::CORE_W-1:0];
                    end
                    tllcp_pkg::CFG_PERF_COUNT:
                    begin
                        perf_count_reg <= cfg_data[tllcp_pkg::CORE_W-1:0];
                    end
                    tllcp_pkg::CFG_THERMAL_ENABLE:
                    begin
                        thermal_enable_reg <= cfg_data[0];
                    end
                    tllcp_pkg::CFG_THERMAL_LIMIT:
                    begin
                        thermal_limit_reg <= cfg_data[tllcp_pkg::TEMP_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            rd_valid_reg <= valid_reg[ram_raddr];
        end
        if (scan_issue)
        begin
            pend_idx_reg <= ptr_reg[AW-1:0];
            ptr_reg      <= ptr_reg + CW'(1);
        end

        if (in_fire)
        begin
            idx_reg        <= AW'(core_index);
            temp_in_reg    <= temperature;
            best_found_reg <= 1'b0;
            if (workload_class == tllcp_pkg::CLASS_COMPUTE)
            begin
                ptr_reg          <= '0;
                hi_reg           <= n_perf;
                scan_thermal_reg <= 1'b1;
                fallback_reg     <= 1'b0;
            end
            else
            begin
                ptr_reg          <= n_perf;
                hi_reg           <= n_present;
                scan_thermal_reg <= 1'b0;
                fallback_reg     <= 1'b1;
            end
        end
        else if (scan_end && run_fallback)
        begin
            // Fallback over the performance cores, keeping the best so far.
            ptr_reg          <= '0;
            hi_reg           <= n_perf;
            scan_thermal_reg <= 1'b0;
            fallback_reg     <= 1'b0;
        end

        if (cand_ok)
        begin
            best_found_reg <= 1'b1;
            best_idx_reg   <= pend_idx_reg;
            best_entry_reg <= rd_entry;
        end

        // Refused items report zeros in the core fields.
        if ((in_fire && (func == tllcp_pkg::FUNC_UPDATE) && !upd_in_range) ||
            (scan_end && !run_fallback && !best_found_reg))
        begin
            res_granted_reg <= 1'b0;
            res_core_reg    <= '0;
            res_perf_reg    <= 1'b0;
            res_load_reg    <= '0;
            res_usable_reg  <= 1'b0;
        end
        else if (state_reg == tllcp_pkg::ST_UPD_WR)
        begin
            res_granted_reg <= 1'b1;
            res_core_reg    <= idx_reg;
            res_perf_reg    <= (CW'(idx_reg) < n_perf);
            res_load_reg    <= upd_entry.load;
            res_usable_reg  <= upd_entry.usable;
        end
        else if (state_reg == tllcp_pkg::ST_GRANT)
        begin
            res_granted_reg <= 1'b1;
            res_core_reg    <= best_idx_reg;
            res_perf_reg    <= grant_is_perf;
            res_load_reg    <= grant_entry.load;
            res_usable_reg  <= grant_entry.usable;
        end

        if (out_load)
        begin
            granted_reg       <= res_granted_reg;
            chosen_core_reg   <= tllcp_pkg::CORE_W'(res_core_reg);
            is_perf_core_reg  <= res_perf_reg;
            core_load_now_reg <= tllcp_pkg::LOAD_OUT_W'(res_load_reg);
            core_usable_reg   <= res_usable_reg;
            perf_grants_reg   <= perf_cnt_reg;
            eff_grants_reg    <= eff_cnt_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted       = granted_reg;
    assign chosen_core   = chosen_core_reg;
    assign is_perf_core  = is_perf_core_reg;
    assign core_load_now = core_load_now_reg;
    assign core_usable   = core_usable_reg;
    assign perf_grants   = perf_grants_reg;
    assign eff_grants    = eff_grants_reg;

    // The core table is written only by a grant or a temperature update.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == tllcp_pkg::ST_GRANT || state_reg == tllcp_pkg::ST_UPD_WR))
        else $error("core table written outside a write-back state");

    // The scan pointer never runs past the end of its range.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tllcp_pkg::ST_SCAN) |-> (ptr_reg <= hi_reg))
        else $error("scan pointer beyond range");

    // At most one grant counter moves per cycle, and neither ever goes down.
    a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
        !((perf_cnt_next != perf_cnt_reg) && (eff_cnt_next != eff_cnt_reg)))
        else $error("both grant counters changed together");

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (perf_cnt_next >= perf_cnt_reg) && (eff_cnt_next >= eff_cnt_reg))
        else $error("grant counter decreased");

    // A finished result waits while the output register holds an untaken word.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tllcp_pkg::ST_RESULT && out_valid_reg && !out_ready)
        |=> (state_reg == tllcp_pkg::ST_RESULT))
        else $error("result overwrote an untaken output word");

endmodule

`default_nettype wire

FILE: tb/typed_least_loaded_core_picker_top_test.sv
`default_nettype none

module typed_least_loaded_core_picker_top_test;

    // Size of the core table in the block, and the longest stretch of cycles
    // in which no word may move on any channel before the run is abandoned.
    localparam int NCORES      = 20;
    localparam int STUCK_LIMIT = 3000;
    localparam int ITEM_GOAL   = 1150;

    // An index past the last register; a write to it must change nothing.
    localparam logic [tllcp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    // One entry of the stimulus backlog: either a register write or an item.
    typedef struct {
        bit                               is_cfg;
        logic [tllcp_pkg::CFG_IDX_W-1:0]  reg_sel;
        logic [tllcp_pkg::CFG_DATA_W-1:0] reg_val;
        logic                             fn;
        logic [tllcp_pkg::CLASS_W-1:0]    wclass;
        logic [tllcp_pkg::CORE_W-1:0]     idx;
        logic [tllcp_pkg::TEMP_W-1:0]     temp;
    } job_t;

    // The result word that one item is expected to produce.
    typedef struct {
        logic                             granted;
        logic [tllcp_pkg::CORE_W-1:0]     core;
        logic                             perf;
        logic [tllcp_pkg::LOAD_OUT_W-1:0] load;
        logic                             usable;
        logic [tllcp_pkg::GRANT_W-1:0]    perf_total;
        logic [tllcp_pkg::GRANT_W-1:0]    eff_total;
    } grant_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [tllcp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tllcp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic                             func = tllcp_pkg::FUNC_PLACE;
    logic [tllcp_pkg::CLASS_W-1:0]    workload_class = '0;
    logic [tllcp_pkg::CORE_W-1:0]     core_index = '0;
    logic [tllcp_pkg::TEMP_W-1:0]     temperature = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic                             granted;
    logic [tllcp_pkg::CORE_W-1:0]     chosen_core;
    logic                             is_perf_core;
    logic [tllcp_pkg::LOAD_OUT_W-1:0] core_load_now;
    logic                             core_usable;
    logic [tllcp_pkg::GRANT_W-1:0]    perf_grants;
    logic [tllcp_pkg::GRANT_W-1:0]    eff_grants;

    typed_least_loaded_core_picker_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: the settings and the per-core table as the block
    // should hold them after every accepted word.
    // ------------------------------------------------------------------
    logic [tllcp_pkg::CORE_W-1:0]     core_count_m;
    logic [tllcp_pkg::CORE_W-1:0]     perf_count_m;
    logic                             therm_en_m;
    logic [tllcp_pkg::TEMP_W-1:0]     therm_lim_m;
    logic [tllcp_pkg::LOAD_OUT_W-1:0] load_tab [NCORES];
    bit                               usable_tab [NCORES];
    logic [tllcp_pkg::TEMP_W-1:0]     temp_tab [NCORES];
    logic [tllcp_pkg::GRANT_W-1:0]    perf_grants_m;
    logic [tllcp_pkg::GRANT_W-1:0]    eff_grants_m;

    initial
    begin
        core_count_m  = tllcp_pkg::CORE_COUNT_RST;
        perf_count_m  = tllcp_pkg::PERF_COUNT_RST;
        therm_en_m    = tllcp_pkg::THERMAL_ENABLE_RST;
        therm_lim_m   = tllcp_pkg::THERMAL_LIMIT_RST;
        perf_grants_m = '0;
        eff_grants_m  = '0;
        for (int c = 0; c < NCORES; c++)
        begin
            load_tab[c]   = '0;
            usable_tab[c] = 1'b1;
            temp_tab[c]   = '0;
        end
    end

    job_t   item_backlog [$];
    grant_t awaited_grants [$];
    int     mismatches = 0;
    int     results_seen = 0;
    int     drv_calm = 0;
    int     mon_calm = 0;

    // A core is too hot only while thermal exclusion is enabled.
    function automatic bit core_hot(input int c);
        return therm_en_m && (temp_tab[c] > therm_lim_m);
    endfunction

    // Walk cores lo..hi-1 and keep the usable one with the strictly lowest
    // load, so that a tie stays with the earlier (lower) index.
    function automatic void scan_cores(input int lo, input int hi, input bit thermal,
                                       inout int best, inout int least);
        for (int c = lo; c < hi; c++)
        begin
            if (usable_tab[c] && !(thermal && core_hot(c)) && (int'(load_tab[c]) < least))
            begin
                least = int'(load_tab[c]);
                best  = c;
            end
        end
    endfunction

    // Works out the result word for one accepted item and advances the table.
    function automatic grant_t predict_word(input logic fn,
                                            input logic [tllcp_pkg::CLASS_W-1:0] wc,
                                            input logic [tllcp_pkg::CORE_W-1:0] ci,
                                            input logic [tllcp_pkg::TEMP_W-1:0] tp);
        grant_t r;
        int     present;
        int     perf_end;
        int     best;
        int     least;
        present  = (int'(core_count_m) < NCORES) ? int'(core_count_m) : NCORES;
        perf_end = (int'(perf_count_m) < present) ? int'(perf_count_m) : present;
        best     = -1;
        least    = 1 << 30;
        if (fn == tllcp_pkg::FUNC_UPDATE)
        begin
            if (int'(ci) < present)
            begin
                temp_tab[ci]   = tp;
                usable_tab[ci] = !core_hot(int'(ci));
                best           = int'(ci);
            end
        end
        else
        begin
            if (wc == tllcp_pkg::CLASS_COMPUTE)
            begin
                scan_cores(0, perf_end, 1'b1, best, least);
            end
            else
            begin
                // Efficiency cores first; the performance cores get the work
                // only when no efficiency core is free or the best is overloaded.
                scan_cores(perf_end, present, 1'b0, best, least);
                if (best < 0 || least > tllcp_pkg::OVERLOAD_LIMIT)
                begin
                    scan_cores(0, perf_end, 1'b0, best, least);
                end
            end
            if (best >= 0)
            begin
                if (load_tab[best] != '1)
                begin
                    load_tab[best] = load_tab[best] + 1'b1;
                end
                if (best < perf_end)
                begin
                    if (perf_grants_m != '1)
                    begin
                        perf_grants_m = perf_grants_m + 1'b1;
                    end
                end
                else if (eff_grants_m != '1)
                begin
                    eff_grants_m = eff_grants_m + 1'b1;
                end
            end
        end
        r.granted = 1'b0;
        r.core    = '0;
        r.perf    = 1'b0;
        r.load    = '0;
        r.usable  = 1'b0;
        if (best >= 0)
        begin
            r.granted = 1'b1;
            r.core    = best[tllcp_pkg::CORE_W-1:0];
            r.perf    = (best < perf_end);
            r.load    = load_tab[best];
            r.usable  = usable_tab[best];
        end
        r.perf_total = perf_grants_m;
        r.eff_total  = eff_grants_m;
        return r;
    endfunction

    function automatic void apply_setting(input logic [tllcp_pkg::CFG_IDX_W-1:0] sel,
                                          input logic [tllcp_pkg::CFG_DATA_W-1:0] val);
        case (sel)
            tllcp_pkg::CFG_CORE_COUNT:     core_count_m = val[tllcp_pkg::CORE_W-1:0];
            tllcp_pkg::CFG_PERF_COUNT:     perf_count_m = val[tllcp_pkg::CORE_W-1:0];
            tllcp_pkg::CFG_THERMAL_ENABLE: therm_en_m   = val[0];
            tllcp_pkg::CFG_THERMAL_LIMIT:  therm_lim_m  = val[tllcp_pkg::TEMP_W-1:0];
            default:                       ;
        endcase
    endfunction

    // Idle length for either side: mostly none or a short one, now and then
    // a long one, and occasionally a stretch of several dozen draws with none.
    function automatic int draw_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver. Items go out whenever the previous word has been taken and
    // the current gap has run out. A register write waits until the block is
    // idle: no item on the input and every result word already collected.
    // results_seen is updated by the monitor with a nonblocking assignment,
    // so its value here is the one from before this edge.
    // ------------------------------------------------------------------
    int items_taken = 0;
    int writes_taken = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        job_t head;
        bit   want_in;
        bit   want_cfg;
        int   idle_left;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
            idle_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                awaited_grants.push_back(predict_word(func, workload_class, core_index,
                                                      temperature));
                items_taken++;
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_setting(cfg_index, cfg_data);
                writes_taken++;
            end
            want_in  = in_valid && !in_ready;
            want_cfg = cfg_valid && !cfg_ready;
            if (!want_in && !want_cfg)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                end
                else if (item_backlog.size() > 0)
                begin
                    head = item_backlog[0];
                    if (!head.is_cfg)
                    begin
                        head = item_backlog.pop_front();
                        want_in = 1'b1;
                        func           <= head.fn;
                        workload_class <= head.wclass;
                        core_index     <= head.idx;
                        temperature    <= head.temp;
                        idle_left = draw_gap(drv_calm);
                    end
                    else if (!in_valid && items_taken == results_seen)
                    begin
                        head = item_backlog.pop_front();
                        want_cfg = 1'b1;
                        cfg_index <= head.reg_sel;
                        cfg_data  <= head.reg_val;
                    end
                end
            end
            in_valid  <= want_in;
            cfg_valid <= want_cfg;
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Every result word is checked against the oldest expectation.
    // The ready line drops at random, whether or not a word is waiting.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        grant_t want;
        int     stall_left;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (awaited_grants.size() == 0)
                begin
                    $display("%0t: result word with none expected, expected nothing, got core %0d",
                             $time, chosen_core);
                    mismatches++;
                end
                else
                begin
                    want = awaited_grants.pop_front();
                    compare_field("granted", 32'(want.granted), 32'(granted));
                    compare_field("chosen_core", 32'(want.core), 32'(chosen_core));
                    compare_field("is_perf_core", 32'(want.perf), 32'(is_perf_core));
                    compare_field("core_load_now", 32'(want.load), 32'(core_load_now));
                    compare_field("core_usable", 32'(want.usable), 32'(core_usable));
                    compare_field("perf_grants", want.perf_total, perf_grants);
                    compare_field("eff_grants", want.eff_total, eff_grants);
                end
            end
            if (stall_left == 0 && $urandom_range(0, 5) == 0)
            begin
                stall_left = draw_gap(mon_calm);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a run that stops moving words on every channel has hung.
    int stuck = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (cfg_valid && cfg_ready) ||
            (out_valid && out_ready))
        begin
            stuck <= 0;
        end
        else if (stuck >= STUCK_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
        begin
            stuck <= stuck + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. The generator tracks the settings it has scheduled so that
    // temperatures can be aimed at the thermal limit and core indexes at the
    // present cores; the predictor tracks the settings actually written.
    // ------------------------------------------------------------------
    int gen_cores = NCORES;
    int gen_limit = int'(tllcp_pkg::THERMAL_LIMIT_RST);
    int items_queued = 0;
    int placements_queued = 0;
    int phases_run = 0;

    task automatic queue_item(input logic fn, input int wc, input int ci, input int tp);
        job_t j;
        j.is_cfg  = 1'b0;
        j.reg_sel = '0;
        j.reg_val = '0;
        j.fn      = fn;
        j.wclass  = wc[tllcp_pkg::CLASS_W-1:0];
        j.idx     = ci[tllcp_pkg::CORE_W-1:0];
        j.temp    = tp[tllcp_pkg::TEMP_W-1:0];
        item_backlog.push_back(j);
        items_queued++;
        if (fn == tllcp_pkg::FUNC_PLACE)
        begin
            placements_queued++;
        end
    endtask

    task automatic queue_setting(input logic [tllcp_pkg::CFG_IDX_W-1:0] sel, input int val);
        job_t j;
        j.is_cfg  = 1'b1;
        j.reg_sel = sel;
        j.reg_val = val[tllcp_pkg::CFG_DATA_W-1:0];
        j.fn      = tllcp_pkg::FUNC_PLACE;
        j.wclass  = '0;
        j.idx     = '0;
        j.temp    = '0;
        item_backlog.push_back(j);
    endtask

    task automatic queue_settings(input int cc, input int pc, input int en, input int lim);
        queue_setting(tllcp_pkg::CFG_CORE_COUNT, cc);
        queue_setting(tllcp_pkg::CFG_PERF_COUNT, pc);
        queue_setting(tllcp_pkg::CFG_THERMAL_ENABLE, en);
        queue_setting(tllcp_pkg::CFG_THERMAL_LIMIT, lim);
        gen_cores = (cc < NCORES) ? cc : NCORES;
        gen_limit = lim;
        phases_run++;
    endtask

    // Random items: a little over half are placements, with compute work
    // favored; updates mostly hit present cores with temperatures close to
    // the limit so that cores keep dropping out and coming back.
    task automatic queue_random_items(input int count);
        int r;
        int wc;
        int ci;
        int tp;
        repeat (count)
        begin
            r  = $urandom_range(0, 99);
            wc = $urandom_range(0, 1) ? int'(tllcp_pkg::CLASS_COMPUTE) : $urandom_range(0, 7);
            ci = $urandom_range(0, 31);
            tp = $urandom_range(0, 4095);
            if (r < 55)
            begin
                queue_item(tllcp_pkg::FUNC_PLACE, wc, ci, tp);
            end
            else
            begin
                if (r < 93 && gen_cores > 0)
                begin
                    ci = $urandom_range(0, gen_cores - 1);
                end
                else
                begin
                    ci = $urandom_range(gen_cores, 31);
                end
                if ($urandom_range(0, 9) < 6)
                begin
                    tp = gen_limit + $urandom_range(0, 6) - 3;
                    tp = (tp < 0) ? 0 : ((tp > 4095) ? 4095 : tp);
                end
                queue_item(tllcp_pkg::FUNC_UPDATE, wc, ci, tp);
            end
        end
    endtask

    function automatic int pick_count(input int spread);
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return spread;
            2:       return 31;
            default: return $urandom_range(1, spread);
        endcase
    endfunction

    initial
    begin : stimulus_proc
        int cc;
        int lim;
        int compute_class;
        int limit_rst;

        compute_class = int'(tllcp_pkg::CLASS_COMPUTE);
        limit_rst     = int'(tllcp_pkg::THERMAL_LIMIT_RST);

        // Directed part, at the reset settings: cores 0..9 are performance
        // cores, 10..19 efficiency cores, limit 90 degrees, exclusion on.
        queue_item(tllcp_pkg::FUNC_PLACE, compute_class, 0, 0);
        for (int wc = 0; wc < 8; wc++)
        begin
            if (wc != compute_class)
            begin
                queue_item(tllcp_pkg::FUNC_PLACE, wc, 31, 4095);
            end
        end
        queue_item(tllcp_pkg::FUNC_UPDATE, 0, 0, 4095);   // hottest reading takes core 0 out
        queue_item(tllcp_pkg::FUNC_UPDATE, 7, 1, 1440);   // exactly at the limit is still fine
        queue_item(tllcp_pkg::FUNC_UPDATE, 1, 2, 1441);   // one step above is too hot
        queue_item(tllcp_pkg::FUNC_UPDATE, 0, 19, 0);
        queue_item(tllcp_pkg::FUNC_UPDATE, 0, 20, 100);   // index past the present cores
        queue_item(tllcp_pkg::FUNC_UPDATE, 0, 31, 4095);
        queue_item(tllcp_pkg::FUNC_PLACE, compute_class, 0, 0);
        queue_item(tllcp_pkg::FUNC_PLACE, compute_class, 0, 0);
        queue_item(tllcp_pkg::FUNC_UPDATE, 0, 0, 0);      // core 0 cools down and returns
        queue_item(tllcp_pkg::FUNC_PLACE, compute_class, 0, 0);

        // One efficiency core: load it past the overload point so that the
        // next request spills over to the performance cores.
        queue_settings(3, 2, 1, limit_rst);
        queue_item(tllcp_pkg::FUNC_UPDATE, 0, 2, 0);
        repeat (6)
        begin
            queue_item(tllcp_pkg::FUNC_PLACE, 0, 0, 0);
        end
        queue_item(tllcp_pkg::FUNC_PLACE, compute_class, 0, 0);

        // Extreme settings: no cores at all, everything at its maximum with a
        // zero limit, more performance cores than cores with exclusion off,
        // a single efficiency core, and all-efficiency and all-performance.
        queue_settings(0, 10, 1, 1440);
        queue_random_items(12);
        queue_settings(31, 31, 1, 0);
        queue_setting(CFG_SPARE, 12'hfff);
        queue_random_items(40);
        queue_settings(3, 20, 0, 4095);
        queue_random_items(40);
        queue_settings(1, 0, 1, 4095);
        queue_random_items(30);
        queue_settings(20, 0, 1, 1440);
        queue_random_items(60);
        queue_settings(20, 20, 1, 1440);
        queue_random_items(60);

        // Random settings, the extremes favored.
        while (items_queued < ITEM_GOAL)
        begin
            cc = pick_count(NCORES);
            case ($urandom_range(0, 3))
                0:       lim = 0;
                1:       lim = 4095;
                2:       lim = limit_rst;
                default: lim = $urandom_range(0, 4095);
            endcase
            queue_settings(cc, pick_count(NCORES), $urandom_range(0, 1), lim);
            queue_random_items($urandom_range(40, 110));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the backlog to drain and every result to come back, then
        // allow the longest placement time for any stray word to show up.
        do
        begin
            @(posedge clk);
        end
        while (item_backlog.size() != 0 || in_valid || cfg_valid || awaited_grants.size() != 0);
        repeat (60) @(posedge clk);

        while (awaited_grants.size() != 0)
        begin
            $display("%0t: result never arrived, expected core %0d, got none",
                     $time, awaited_grants[0].core);
            void'(awaited_grants.pop_front());
            mismatches++;
        end

        $display("Covered %0d items (%0d placements) and %0d register writes over %0d settings.",
                 items_taken, placements_queued, writes_taken, phases_run + 1);
        $display("Grants predicted: %0d to performance cores, %0d to efficiency cores.",
                 perf_grants_m, eff_grants_m);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
